// File: src/cxalu_pkg.sv
`default_nettype none
package cxalu_pkg;

   localparam int FRAC_BITS_DEF = 16;
   // Quotient bits produced by the divider; any larger quotient saturates.
   localparam int DIV_QBITS = 34;
   localparam int STEP_W = 6;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4
   } cmd_type;

   // Order in which the shared multiplier forms the partial products.
   typedef enum logic [2:0] {
      PRD_AC = 3'd0,
      PRD_BD = 3'd1,
      PRD_BC = 3'd2,
      PRD_AD = 3'd3,
      PRD_CC = 3'd4,
      PRD_DD = 3'd5
   } prd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_LOAD,
      ST_DIV_ITER,
      ST_DIV_STORE,
      ST_WB
   } ctl_state_type;

   typedef struct packed {
      logic    capture;
      logic    mul_en;
      prd_type mul_sel;
      logic    acc_en;
      prd_type acc_sel;
      logic    div_load;
      logic    div_iter;
      logic    div_store;
      logic    div_part;
      logic    write_back;
   } dp_cmd_type;

endpackage
`default_nettype wire

// File: src/cxalu_ctrl.sv
`default_nettype none
module cxalu_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_command,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output cxalu_pkg::dp_cmd_type      dp_cmd
);
   import cxalu_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              part_ff, part_in;
   logic              is_div_ff, is_div_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;
   logic [STEP_W-1:0] last_step;
   logic [STEP_W-1:0] step_m1;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Multiply ends after accumulating a*d; divide also needs c*c + d*d.
   assign last_step = is_div_ff ? STEP_W'(PRD_DD + 1) : STEP_W'(PRD_AD + 1);
   assign step_m1   = step_ff - STEP_W'(1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      part_in   = part_ff;
      is_div_in = is_div_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in   = '0;
               part_in   = 1'b0;
               is_div_in = (req_command == CMD_DIV);
               if (req_command == CMD_MUL || req_command == CMD_DIV) begin
                  state_in = ST_PROD;
               end else begin
                  state_in = ST_WB;
               end
            end
         end
         ST_PROD: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == last_step) begin
               step_in  = '0;
               state_in = is_div_ff ? ST_DIV_LOAD : ST_WB;
            end
         end
         ST_DIV_LOAD: begin
            step_in  = '0;
            state_in = ST_DIV_ITER;
         end
         ST_DIV_ITER: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_QBITS - 1)) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            if (!part_ff) begin
               part_in  = 1'b1;
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready          = (state_ff == ST_IDLE);
      dp_cmd             = '0;
      dp_cmd.capture     = accept;
      dp_cmd.div_part    = part_ff;
      dp_cmd.mul_sel     = prd_type'(step_ff[2:0]);
      dp_cmd.acc_sel     = prd_type'(step_m1[2:0]);
      unique case (state_ff)
         ST_PROD: begin
            dp_cmd.mul_en = (step_ff <= STEP_W'(PRD_DD));
            dp_cmd.acc_en = (step_ff != '0);
         end
         ST_DIV_LOAD:  dp_cmd.div_load   = 1'b1;
         ST_DIV_ITER:  dp_cmd.div_iter   = 1'b1;
         ST_DIV_STORE: dp_cmd.div_store  = 1'b1;
         ST_WB:        dp_cmd.write_back = out_free;
         default: ;
      endcase
      if (dp_cmd.write_back) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         part_ff      <= 1'b0;
         is_div_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         part_ff      <= part_in;
         is_div_ff    <= is_div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: src/cxalu_dp.sv
`default_nettype none
module cxalu_dp #(
   parameter int FRAC_BITS = cxalu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cxalu_pkg::dp_cmd_type dp_cmd,
   input  wire logic [2:0]            req_command,
   input  wire logic signed [31:0]    req_operand_re,
   input  wire logic signed [31:0]    req_operand_im,
   output logic signed [31:0]         rsp_value_re,
   output logic signed [31:0]         rsp_value_im,
   output logic                       rsp_operand_equal,
   output logic                       rsp_overflow,
   output logic                       rsp_divide_by_zero
);
   import cxalu_pkg::*;

   localparam int NW = 64 + FRAC_BITS;
   localparam int HW = NW - DIV_QBITS;

   // Clamp a sign/magnitude value; bit 32 of the result is the overflow flag.
   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(~mag + 64'd1)};
      end else begin
         if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

   function automatic logic [32:0] sat_sum(input logic [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
      else r = {1'b0, s[31:0]};
      return r;
   endfunction

   function automatic logic [63:0] abs65(input logic [64:0] v);
      logic [64:0] n;
      n = ~v + 65'd1;
      return v[64] ? n[63:0] : v[63:0];
   endfunction

   logic signed [31:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [31:0] opd_re_ff, opd_im_ff;
   logic [2:0]         cmd_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_x, mul_y;
   logic signed [64:0] num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        rem_ff, rem_in;
   logic [DIV_QBITS-1:0] low_ff, low_in, quo_ff, quo_in;
   logic               big_ff, big_in, neg_ff, neg_in;
   logic [32:0]        qre_ff, qre_in, qim_ff, qim_in;
   logic [64:0]        p65;
   logic [64:0]        dsel;
   logic [63:0]        dmag;
   logic [NW-1:0]      dnum;
   logic [HW-1:0]      dhigh;
   logic [64:0]        r2;
   logic [64:0]        r2_sub;
   logic               ge;
   logic [63:0]        qmag;
   logic [32:0]        qsat;
   logic [32:0]        res_re, res_im;
   logic               dz;
   logic               eq;

   always_comb begin
      unique case (dp_cmd.mul_sel)
         PRD_AC:  begin mul_x = acc_re_ff; mul_y = opd_re_ff; end
         PRD_BD:  begin mul_x = acc_im_ff; mul_y = opd_im_ff; end
         PRD_BC:  begin mul_x = acc_im_ff; mul_y = opd_re_ff; end
         PRD_AD:  begin mul_x = acc_re_ff; mul_y = opd_im_ff; end
         PRD_CC:  begin mul_x = opd_re_ff; mul_y = opd_re_ff; end
         PRD_DD:  begin mul_x = opd_im_ff; mul_y = opd_im_ff; end
         default: begin mul_x = opd_im_ff; mul_y = opd_im_ff; end
      endcase
      prod_in = dp_cmd.mul_en ? (64'(mul_x) * 64'(mul_y)) : prod_ff;
   end

   // Real numerator: ac - bd for multiply, ac + bd for divide.
   // Imaginary numerator: bc + ad for multiply, bc - ad for divide.
   always_comb begin
      p65       = {prod_ff[63], prod_ff};
      num_re_in = num_re_ff;
      num_im_in = num_im_ff;
      den_in    = den_ff;
      if (dp_cmd.acc_en) begin
         unique case (dp_cmd.acc_sel)
            PRD_AC: num_re_in = p65;
            PRD_BD: num_re_in = (cmd_ff == CMD_DIV) ? num_re_ff + p65 : num_re_ff - p65;
            PRD_BC: num_im_in = p65;
            PRD_AD: num_im_in = (cmd_ff == CMD_DIV) ? num_im_ff - p65 : num_im_ff + p65;
            PRD_CC: den_in = prod_ff;
            PRD_DD: den_in = den_ff + prod_ff;
            default: ;
         endcase
      end
   end

   // Restoring division of (|num| << FRAC_BITS) by the denominator. The high
   // part is checked first: if it is not below the denominator, the quotient
   // is too large for any unsaturated result.
   always_comb begin
      dsel   = dp_cmd.div_part ? num_im_ff : num_re_ff;
      dmag   = abs65(dsel);
      dnum   = {dmag, {FRAC_BITS{1'b0}}};
      dhigh  = dnum[NW-1:DIV_QBITS];
      r2     = {rem_ff, low_ff[DIV_QBITS-1]};
      r2_sub = r2 - {1'b0, den_ff};
      ge     = (r2 >= {1'b0, den_ff});
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      big_in = big_ff;
      neg_in = neg_ff;
      if (dp_cmd.div_load) begin
         rem_in = {{(64 - HW){1'b0}}, dhigh};
         low_in = dnum[DIV_QBITS-1:0];
         quo_in = '0;
         big_in = ({{(64 - HW){1'b0}}, dhigh} >= den_ff);
         neg_in = dsel[64];
      end else if (dp_cmd.div_iter) begin
         rem_in = ge ? r2_sub[63:0] : r2[63:0];
         low_in = {low_ff[DIV_QBITS-2:0], 1'b0};
         quo_in = {quo_ff[DIV_QBITS-2:0], ge};
      end
      qmag   = big_ff ? 64'h1_0000_0000 : {{(64 - DIV_QBITS){1'b0}}, quo_ff};
      qsat   = sat_mag(neg_ff, qmag);
      qre_in = (dp_cmd.div_store && !dp_cmd.div_part) ? qsat : qre_ff;
      qim_in = (dp_cmd.div_store && dp_cmd.div_part) ? qsat : qim_ff;
   end

   always_comb begin
      eq     = (acc_re_ff == opd_re_ff) && (acc_im_ff == opd_im_ff);
      dz     = 1'b0;
      res_re = {1'b0, acc_re_ff};
      res_im = {1'b0, acc_im_ff};
      unique case (cmd_ff)
         CMD_LOAD: begin
            res_re = {1'b0, opd_re_ff};
            res_im = {1'b0, opd_im_ff};
         end
         CMD_ADD: begin
            res_re = sat_sum({acc_re_ff[31], acc_re_ff} + {opd_re_ff[31], opd_re_ff});
            res_im = sat_sum({acc_im_ff[31], acc_im_ff} + {opd_im_ff[31], opd_im_ff});
         end
         CMD_SUB: begin
            res_re = sat_sum({acc_re_ff[31], acc_re_ff} - {opd_re_ff[31], opd_re_ff});
            res_im = sat_sum({acc_im_ff[31], acc_im_ff} - {opd_im_ff[31], opd_im_ff});
         end
         CMD_MUL: begin
            res_re = sat_mag(num_re_ff[64], abs65(num_re_ff) >> FRAC_BITS);
            res_im = sat_mag(num_im_ff[64], abs65(num_im_ff) >> FRAC_BITS);
         end
         CMD_DIV: begin
            if (opd_re_ff == '0 && opd_im_ff == '0) begin
               dz = 1'b1;
            end else begin
               res_re = qre_ff;
               res_im = qim_ff;
            end
         end
         default: ;
      endcase
      acc_re_in = dp_cmd.write_back ? res_re[31:0] : acc_re_ff;
      acc_im_in = dp_cmd.write_back ? res_im[31:0] : acc_im_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff    <= req_command;
         opd_re_ff <= req_operand_re;
         opd_im_ff <= req_operand_im;
      end
      prod_ff   <= prod_in;
      num_re_ff <= num_re_in;
      num_im_ff <= num_im_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      big_ff    <= big_in;
      neg_ff    <= neg_in;
      qre_ff    <= qre_in;
      qim_ff    <= qim_in;
      if (dp_cmd.write_back) begin
         rsp_value_re       <= res_re[31:0];
         rsp_value_im       <= res_im[31:0];
         rsp_operand_equal  <= eq;
         rsp_overflow       <= res_re[32] | res_im[32];
         rsp_divide_by_zero <= dz;
      end
   end

endmodule
`default_nettype wire

// File: src/complex_accumulator_alu_core.sv
// From the accepting edge to the registered result: load, add, subtract and unknown commands
// go straight to write-back; multiply forms four products on one shared 32x32 multiplier;
// divide forms six products, then runs two 34-step restoring divisions on one shared divider.
// Throughput: one item at a time; the block is ready again in the same cycle that the result is
// registered, and it waits in write-back while the output is stalled.
// Reset (synchronous, active high) clears the stored value to 0 + 0i and the control.
`default_nettype none
module complex_accumulator_alu_core #(
   parameter int FRAC_BITS = cxalu_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_operand_re,
   input  wire logic signed [31:0] req_operand_im,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_value_re,
   output logic signed [31:0]      rsp_value_im,
   output logic                    rsp_operand_equal,
   output logic                    rsp_overflow,
   output logic                    rsp_divide_by_zero
);
   import cxalu_pkg::*;

   dp_cmd_type dp_cmd;

   cxalu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd)
   );

   cxalu_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .req_command        (req_command),
      .req_operand_re     (req_operand_re),
      .req_operand_im     (req_operand_im),
      .rsp_value_re       (rsp_value_re),
      .rsp_value_im       (rsp_value_im),
      .rsp_operand_equal  (rsp_operand_equal),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule
`default_nettype wire
